### hw/rtl/sihs_pkg.sv
// session invite handshake: shared types, codes and reset values
// no dependencies; used by every other file of the block
package sihs_pkg;

	localparam int TIME_W  = 32;
	localparam int TO_W    = 20;
	localparam int EV_W    = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [TO_W-1:0] INVITE_TO_RESET  = 20'd10000;
	localparam logic [TO_W-1:0] WAITING_TO_RESET = 20'd15000;

	localparam logic [CFG_IDX_W-1:0] CFG_INVITE_TO  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAITING_TO = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE         = 3'd0,
		ST_INVITING     = 3'd1,
		ST_WAITING      = 3'd2,
		ST_CONNECTED    = 3'd3,
		ST_PLAYING      = 3'd4,
		ST_DISCONNECTED = 3'd5
	} state_t;

	typedef enum logic [2:0] {
		CMD_POLL       = 3'd0,
		CMD_INVITE     = 3'd1,
		CMD_ACCEPT     = 3'd2,
		CMD_REJECT     = 3'd3,
		CMD_CANCEL     = 3'd4,
		CMD_DISCONNECT = 3'd5,
		CMD_START_PLAY = 3'd6,
		CMD_EXIT_PLAY  = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		TX_NONE       = 3'd0,
		TX_INVITE     = 3'd1,
		TX_ACK_ACCEPT = 3'd2,
		TX_ACK_REJECT = 3'd3,
		TX_CANCEL     = 3'd4,
		TX_DISCONNECT = 3'd5
	} tx_t;

	localparam logic [1:0] LINK_UP    = 2'd0;
	localparam logic [1:0] LINK_DOWN  = 2'd1;
	localparam logic [1:0] LINK_ERROR = 2'd2;
	localparam logic [1:0] LINK_OTHER = 2'd3;

	localparam logic [EV_W-1:0] EV_NONE         = 7'h00;
	localparam logic [EV_W-1:0] EV_RECEIVED     = 7'h01;
	localparam logic [EV_W-1:0] EV_ACCEPTED     = 7'h02;
	localparam logic [EV_W-1:0] EV_REJECTED     = 7'h04;
	localparam logic [EV_W-1:0] EV_INVITE_TO    = 7'h08;
	localparam logic [EV_W-1:0] EV_WAITING_TO   = 7'h10;
	localparam logic [EV_W-1:0] EV_CONNECTED    = 7'h20;
	localparam logic [EV_W-1:0] EV_DISCONNECTED = 7'h40;

	typedef struct packed {
		cmd_t              cmd;
		logic [TIME_W-1:0] now_ms;
		logic              invite_seen;
		logic              ack_seen;
		logic              ack_accepted;
		logic              cancel_seen;
		logic              disconnect_seen;
		logic [1:0]        link_status;
		logic              local_busy;
	} item_t;

	typedef struct packed {
		logic            ok;
		state_t          session_state;
		logic [EV_W-1:0] events;
		tx_t             tx_frame;
	} result_t;

	typedef struct packed {
		logic [TO_W-1:0] invite_timeout_ms;
		logic [TO_W-1:0] waiting_timeout_ms;
	} cfg_t;

endpackage

### hw/rtl/sihs_if.sv
// session invite handshake: valid/ready channel interfaces for request and result beats
// depends on sihs_pkg for widths
interface sihs_req_if;
	logic                       valid;
	logic                       ready;
	logic [2:0]                 cmd;
	logic [sihs_pkg::TIME_W-1:0] now_ms;
	logic                       invite_seen;
	logic                       ack_seen;
	logic                       ack_accepted;
	logic                       cancel_seen;
	logic                       disconnect_seen;
	logic [1:0]                 link_status;
	logic                       local_busy;

	modport source (
		output valid, cmd, now_ms, invite_seen, ack_seen, ack_accepted,
		       cancel_seen, disconnect_seen, link_status, local_busy,
		input  ready
	);
	modport sink (
		input  valid, cmd, now_ms, invite_seen, ack_seen, ack_accepted,
		       cancel_seen, disconnect_seen, link_status, local_busy,
		output ready
	);
endinterface

interface sihs_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      ok;
	logic [2:0]                session_state;
	logic [sihs_pkg::EV_W-1:0] events;
	logic [2:0]                tx_frame;

	modport source (
		output valid, ok, session_state, events, tx_frame,
		input  ready
	);
	modport sink (
		input  valid, ok, session_state, events, tx_frame,
		output ready
	);
endinterface

### hw/rtl/sihs_cfg.sv
// session invite handshake: timeout configuration registers
// depends on sihs_pkg
module sihs_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sihs_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [sihs_pkg::TO_W-1:0]        cfg_wdata,
	output sihs_pkg::cfg_t                   cfg
);
	import sihs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.invite_timeout_ms  <= INVITE_TO_RESET;
			cfg_q.waiting_timeout_ms <= WAITING_TO_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_INVITE_TO:  cfg_q.invite_timeout_ms  <= cfg_wdata;
				CFG_WAITING_TO: cfg_q.waiting_timeout_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> cfg_q == $past(cfg_q))
		else $error("config changed without a write");
endmodule

### hw/rtl/sihs_fsm.sv
// session invite handshake: session state, time stamps and per-beat decision logic
// depends on sihs_pkg
module sihs_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  sihs_pkg::item_t   item,
	input  sihs_pkg::cfg_t    cfg,
	output sihs_pkg::result_t res
);
	import sihs_pkg::*;

	state_t             state_q, state_d;
	logic [TIME_W-1:0]  invite_start_q, waiting_start_q;
	logic               set_invite, set_waiting;
	logic [TIME_W-1:0]  inv_elapsed, wait_elapsed;
	logic               inv_expired, wait_expired;
	logic               link_lost;
	logic               ok;
	logic [EV_W-1:0]    ev;
	tx_t                tx;

	assign inv_elapsed  = item.now_ms - invite_start_q;
	assign wait_elapsed = item.now_ms - waiting_start_q;
	assign inv_expired  = inv_elapsed  >= {{(TIME_W-TO_W){1'b0}}, cfg.invite_timeout_ms};
	assign wait_expired = wait_elapsed >= {{(TIME_W-TO_W){1'b0}}, cfg.waiting_timeout_ms};
	assign link_lost    = item.link_status == LINK_DOWN || item.link_status == LINK_ERROR;

	// next state and stamp loads
	always_comb begin
		state_d     = state_q;
		set_invite  = 1'b0;
		set_waiting = 1'b0;
		case (item.cmd)
			CMD_POLL: begin
				case (state_q)
					ST_IDLE: begin
						if (item.invite_seen) begin
							set_waiting = 1'b1;
							state_d     = item.local_busy ? ST_IDLE : ST_WAITING;
						end
					end
					ST_INVITING: begin
						if (item.ack_seen)
							state_d = item.ack_accepted ? ST_CONNECTED : ST_IDLE;
						else if (inv_expired)
							state_d = ST_IDLE;
					end
					ST_WAITING: begin
						if (item.cancel_seen || wait_expired)
							state_d = ST_IDLE;
						else if (item.invite_seen)
							set_waiting = 1'b1;
					end
					ST_CONNECTED, ST_PLAYING: begin
						if (item.disconnect_seen || link_lost)
							state_d = ST_DISCONNECTED;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			CMD_INVITE: begin
				if (state_q == ST_IDLE && item.link_status == LINK_UP) begin
					state_d    = ST_INVITING;
					set_invite = 1'b1;
				end
			end
			CMD_ACCEPT:     if (state_q == ST_WAITING) state_d = ST_CONNECTED;
			CMD_REJECT:     if (state_q == ST_WAITING) state_d = ST_IDLE;
			CMD_CANCEL:     if (state_q == ST_INVITING) state_d = ST_IDLE;
			CMD_DISCONNECT: begin
				if (state_q == ST_CONNECTED || state_q == ST_PLAYING)
					state_d = ST_DISCONNECTED;
			end
			CMD_START_PLAY: if (state_q == ST_CONNECTED) state_d = ST_PLAYING;
			CMD_EXIT_PLAY:  if (state_q == ST_PLAYING) state_d = ST_CONNECTED;
			default: ;
		endcase
	end

	// result fields
	always_comb begin
		ok = 1'b0;
		ev = EV_NONE;
		tx = TX_NONE;
		case (item.cmd)
			CMD_POLL: begin
				ok = 1'b1;
				case (state_q)
					ST_IDLE: begin
						if (item.invite_seen) begin
							if (item.local_busy)
								tx = TX_ACK_REJECT;
							else
								ev = EV_RECEIVED;
						end
					end
					ST_INVITING: begin
						if (item.ack_seen) begin
							ev = item.ack_accepted ? (EV_ACCEPTED | EV_CONNECTED) : EV_REJECTED;
						end else if (inv_expired) begin
							ev = EV_INVITE_TO;
							tx = TX_CANCEL;
						end
					end
					ST_WAITING: begin
						if (item.cancel_seen || wait_expired)
							ev = EV_WAITING_TO;
						else if (item.invite_seen)
							ev = EV_RECEIVED;
					end
					ST_CONNECTED, ST_PLAYING: begin
						if (item.disconnect_seen || link_lost)
							ev = EV_DISCONNECTED;
					end
					default: ;
				endcase
			end
			CMD_INVITE: begin
				if (state_q == ST_IDLE && item.link_status == LINK_UP) begin
					ok = 1'b1;
					tx = TX_INVITE;
				end
			end
			CMD_ACCEPT: begin
				if (state_q == ST_WAITING) begin
					ok = 1'b1;
					tx = TX_ACK_ACCEPT;
					ev = EV_CONNECTED;
				end
			end
			CMD_REJECT: begin
				if (state_q == ST_WAITING) begin
					ok = 1'b1;
					tx = TX_ACK_REJECT;
				end
			end
			CMD_CANCEL: begin
				if (state_q == ST_INVITING) begin
					ok = 1'b1;
					tx = TX_CANCEL;
				end
			end
			CMD_DISCONNECT: begin
				if (state_q == ST_CONNECTED || state_q == ST_PLAYING) begin
					ok = 1'b1;
					tx = TX_DISCONNECT;
					ev = EV_DISCONNECTED;
				end
			end
			CMD_START_PLAY: ok = state_q == ST_CONNECTED;
			CMD_EXIT_PLAY:  ok = state_q == ST_PLAYING;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			invite_start_q  <= '0;
			waiting_start_q <= '0;
		end else if (adv) begin
			state_q <= state_d;
			if (set_invite)
				invite_start_q <= item.now_ms;
			if (set_waiting)
				waiting_start_q <= item.now_ms;
		end
	end

	assign res.ok            = ok;
	assign res.session_state = state_d;
	assign res.events        = ev;
	assign res.tx_frame      = tx;

	a_refused_holds: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !ok |=> state_q == $past(state_q))
		else $error("refused command changed the state");
	a_poll_ok: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item.cmd == CMD_POLL |-> ok)
		else $error("poll not acknowledged");
	a_invite_enters: assert property (@(posedge clk) disable iff (!arst_n)
		adv && tx == TX_INVITE |=> state_q == ST_INVITING && invite_start_q == $past(item.now_ms))
		else $error("invite sent without entering inviting");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> state_q == $past(state_q))
		else $error("state moved without a beat");
endmodule

### hw/rtl/session_invite_handshake_fsm.sv
// session invite handshake: top level with input stage, result register and config port
// depends on sihs_pkg, sihs_if, sihs_cfg and sihs_fsm
//
//  channel | dir | handshake       | payload
//  req     | in  | valid/ready     | cmd, now_ms, frame flags, link_status, local_busy
//  rsp     | out | valid/ready     | ok, session_state, events, tx_frame
//  cfg     | in  | cfg_we          | cfg_idx, cfg_wdata (write only)
//
// one beat per cycle unless rsp stalls; a result passes both stages before rsp
// state is updated when a beat leaves the input stage for the result register
// req.ready drops only while both stages hold beats and rsp is stalled
// reset clears both stage valids and the session state and restores the default timeouts
module session_invite_handshake_fsm (
	input  logic                           clk,
	input  logic                           arst_n,
	sihs_req_if.sink                       req,
	sihs_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [sihs_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [sihs_pkg::TO_W-1:0]      cfg_wdata
);
	import sihs_pkg::*;

	logic    valid_s1, valid_s2;
	item_t   item_s1;
	result_t res, res_s2;
	cfg_t    cfg;
	logic    out_free, adv, in_take;

	assign out_free  = !valid_s2 || rsp.ready;
	assign adv       = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;
	assign in_take   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready)
				valid_s1 <= req.valid;
			if (out_free)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.cmd             <= cmd_t'(req.cmd);
			item_s1.now_ms          <= req.now_ms;
			item_s1.invite_seen     <= req.invite_seen;
			item_s1.ack_seen        <= req.ack_seen;
			item_s1.ack_accepted    <= req.ack_accepted;
			item_s1.cancel_seen     <= req.cancel_seen;
			item_s1.disconnect_seen <= req.disconnect_seen;
			item_s1.link_status     <= req.link_status;
			item_s1.local_busy      <= req.local_busy;
		end
		if (adv)
			res_s2 <= res;
	end

	sihs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	sihs_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign rsp.valid         = valid_s2;
	assign rsp.ok            = res_s2.ok;
	assign rsp.session_state = res_s2.session_state;
	assign rsp.events        = res_s2.events;
	assign rsp.tx_frame      = res_s2.tx_frame;

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> valid_s1)
		else $error("accepted beat lost at input stage");
	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("beat lost between stages");
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> valid_s1 && valid_s2)
		else $error("input stalled with a free stage");
endmodule
